// ===== rtl/b64enc_pkg.sv =====
// Types, constants and the character mapping shared by the Base64 stream encoder.
package b64enc_pkg;

    localparam logic [6:0] PAD_CHAR     = 7'd61;
    localparam logic [6:0] UPPER_BASE   = 7'd65;
    localparam logic [6:0] LOWER_OFFSET = 7'd71;
    localparam logic [6:0] DIGIT_OFFSET = 7'd4;
    localparam logic [6:0] PLUS_CHAR    = 7'd43;
    localparam logic [6:0] SLASH_CHAR   = 7'd47;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            eob;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = UPPER_BASE + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = LOWER_OFFSET + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            c = {1'b0, v} - DIGIT_OFFSET;
        end
        else if (v == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
// Front end: accepts bytes, tracks the group position and builds the character list of each byte.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    input  in_item_t byte_beat,
    input  q_stat_t  status,
    output logic     push,
    output cmd_t     push_cmd
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [7:0] b;
    logic       last;

    assign b    = byte_beat.data_byte;
    assign last = byte_beat.end_of_buffer;
    assign push = byte_valid && !status.full;

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.eob   = last;
        push_cmd.chars = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
        phase_next     = PHASE_FIRST;
        carry_next     = '0;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                push_cmd.chars[0] = b64_char({carry_reg[1:0], b[7:4]});
                if (last)
                begin
                    push_cmd.chars[1] = b64_char({b[3:0], 2'b00});
                    push_cmd.last_idx = 2'd2;
                end
                else
                begin
                    push_cmd.last_idx = 2'd0;
                    carry_next        = b[3:0];
                    phase_next        = PHASE_THIRD;
                end
            end
            PHASE_THIRD:
            begin
                push_cmd.chars[0] = b64_char({carry_reg, b[7:6]});
                push_cmd.chars[1] = b64_char(b[5:0]);
                push_cmd.last_idx = 2'd1;
            end
            default:
            begin
                push_cmd.chars[0] = b64_char(b[7:2]);
                if (last)
                begin
                    push_cmd.chars[1] = b64_char({b[1:0], 4'b0000});
                    push_cmd.last_idx = 2'd3;
                end
                else
                begin
                    push_cmd.last_idx = 2'd0;
                    carry_next        = {2'b00, b[1:0]};
                    phase_next        = PHASE_SECOND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== rtl/b64enc_fifo.sv =====
// Short command queue between the front end and the back end.
module b64enc_fifo
    import b64enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !status.full)
        else $error("queue written while full");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not follow a write");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== rtl/b64enc_back.sv =====
// Back end: walks the characters of the head command and drives the registered output beat.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head_cmd,
    input  q_stat_t   status,
    output logic      pop,
    output logic      char_valid,
    input  logic      char_stall,
    output out_item_t char_beat
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_beat_reg;
    out_item_t  out_beat_next;
    logic       load;
    logic       emit;
    logic       at_end;

    assign load   = !out_valid_reg || !char_stall;
    assign emit   = load && !status.empty;
    assign at_end = (idx_reg == head_cmd.last_idx);
    assign pop    = emit && at_end;

    assign char_valid = out_valid_reg;
    assign char_beat  = out_beat_reg;

    always_comb
    begin
        out_beat_next.out_char   = head_cmd.chars[idx_reg];
        out_beat_next.run_last   = at_end;
        out_beat_next.stream_end = at_end && head_cmd.eob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= !status.empty;
            end
            if (pop)
            begin
                idx_reg <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !status.empty |-> (idx_reg <= head_cmd.last_idx))
        else $error("character index ran past the end of the command");
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_beat_reg.stream_end) |-> out_beat_reg.run_last)
        else $error("end of stream on a beat that does not close its byte");
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("character index not cleared after a command");
`endif

endmodule

// ===== rtl/base64_stream_encoder_top.sv =====
// Top level of the Base64 stream encoder: front end, command queue and back end.
// One byte beat enters per cycle while the command queue has room, and each byte yields one to
// four Base64 characters ('=' padding included after the flagged last byte), one output beat per
// cycle while char_stall is low, from a registered output stage. The single output character port
// sets the throughput, four characters per three bytes in a steady stream. The first character of
// a byte passes through its command queue entry and then the registered output stage.
// FIFO_DEPTH sets how many encoded bytes may wait between the two ends.
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_beat,
    output logic      char_valid,
    input  logic      char_stall,
    output out_item_t char_beat
);

    q_stat_t status;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    push;
    logic    pop;

    assign byte_stall = status.full;

    b64enc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_beat  (byte_beat),
        .status     (status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    b64enc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    b64enc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .status     (status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat)
    );

endmodule

// ===== sim/base64_stream_encoder_top_test.sv =====
// Self-checking testbench for the Base64 stream encoder with a scoreboard and random flow control.
`timescale 1ns / 100ps

module base64_stream_encoder_top_test;
    import b64enc_pkg::*;

    class b64_scoreboard;
        out_item_t   expected_chars[$];
        phase_t      phase;
        logic [3:0]  carry;
        int          errors;
        int          checked;
        string       alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            phase    = PHASE_FIRST;
            carry    = 4'd0;
            errors   = 0;
            checked  = 0;
        endfunction

        function logic [6:0] sextet_char(input logic [5:0] v);
            byte c;
            c = alphabet[v];
            return c[6:0];
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_byte(input in_item_t b);
            logic [6:0] chars[$];
            int         n;
            out_item_t  e;
            chars.delete();
            case (phase)
                PHASE_SECOND:
                begin
                    chars.push_back(sextet_char({carry[1:0], b.data_byte[7:4]}));
                    if (b.end_of_buffer)
                    begin
                        chars.push_back(sextet_char({b.data_byte[3:0], 2'b00}));
                        chars.push_back(PAD_CHAR);
                        phase = PHASE_FIRST;
                        carry = 4'd0;
                    end
                    else
                    begin
                        carry = b.data_byte[3:0];
                        phase = PHASE_THIRD;
                    end
                end
                PHASE_THIRD:
                begin
                    chars.push_back(sextet_char({carry, b.data_byte[7:6]}));
                    chars.push_back(sextet_char(b.data_byte[5:0]));
                    phase = PHASE_FIRST;
                    carry = 4'd0;
                end
                default:
                begin
                    chars.push_back(sextet_char(b.data_byte[7:2]));
                    if (b.end_of_buffer)
                    begin
                        chars.push_back(sextet_char({b.data_byte[1:0], 4'b0000}));
                        chars.push_back(PAD_CHAR);
                        chars.push_back(PAD_CHAR);
                        phase = PHASE_FIRST;
                        carry = 4'd0;
                    end
                    else
                    begin
                        carry = {2'b00, b.data_byte[1:0]};
                        phase = PHASE_SECOND;
                    end
                end
            endcase
            n = chars.size();
            for (int i = 0; i < n; i++)
            begin
                e.out_char   = chars[i];
                e.run_last   = (i == n - 1);
                e.stream_end = (i == n - 1) && b.end_of_buffer;
                expected_chars.push_back(e);
            end
        endfunction

        function void check_char(input out_item_t got);
            out_item_t e;
            checked++;
            if (expected_chars.size() == 0)
            begin
                $error("Unexpected character beat: out_char %0d", got.out_char);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (got.out_char !== e.out_char)
            begin
                $error("out_char: expected %0d, got %0d", e.out_char, got.out_char);
                errors++;
            end
            if (got.run_last !== e.run_last)
            begin
                $error("run_last: expected %0b, got %0b", e.run_last, got.run_last);
                errors++;
            end
            if (got.stream_end !== e.stream_end)
            begin
                $error("stream_end: expected %0b, got %0b", e.stream_end, got.stream_end);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_beat;
    logic      char_valid;
    logic      char_stall;
    out_item_t char_beat;
    logic      no_idle;

    b64_scoreboard sb;
    int            bytes_sent;
    int            buffers_sent;

    base64_stream_encoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
        begin
            sb.check_char(char_beat);
        end
        char_stall <= !no_idle && ($urandom_range(0, 99) < 6);
    end

    task automatic send_byte(input logic [7:0] data, input logic eob);
        in_item_t b;
        b.data_byte     = data;
        b.end_of_buffer = eob;
        while (!no_idle && ($urandom_range(0, 99) < 6))
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat  <= b;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        bytes_sent++;
        if (eob)
        begin
            buffers_sent++;
        end
    endtask

    task automatic send_random_buffer();
        int         len;
        logic [7:0] data;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:       data = 8'h00;
                1:       data = 8'hFF;
                default: data = 8'($urandom_range(0, 255));
            endcase
            send_byte(data, i == len - 1);
        end
    endtask

    initial
    begin
        sb           = new();
        bytes_sent   = 0;
        buffers_sent = 0;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_beat    = '0;
        no_idle      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Buffers ending at each position in a group, with all-zero, all-one and edge sextets.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hD3, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h37, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);

        while (bytes_sent < 410)
        begin
            no_idle <= (bytes_sent >= 150) && (bytes_sent < 260);
            send_random_buffer();
        end
        byte_valid <= 1'b0;
        no_idle    <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Encoded %0d buffers of %0d bytes in total; %0d characters were checked.",
                 buffers_sent, bytes_sent, sb.checked);
        $display("Gaps and stalls were random on both sides, with one stretch free of both.");
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_fifo.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder_top.sv
sim/base64_stream_encoder_top_test.sv
